/* sv/ptfr_pkg.sv */
// Package for the page translation block with FIFO frame replacement.
// Holds the sizing constants, the status codes, the controller state type
// and the command and status structs. It depends on nothing else.
package ptfr_pkg;

    localparam int PAGE_BYTES    = 4096;
    localparam int FRAME_SLOTS   = 16;
    localparam int VIRTUAL_PAGES = 256;

    localparam int VA_W     = 20;
    localparam int PA_W     = 16;
    localparam int CFG_W    = 5;
    localparam int CNT_W    = 32;
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_W  = $clog2(FRAME_SLOTS);
    localparam int RING_W   = FRAME_W + 1;

    typedef enum logic [1:0] {
        ST_HIT         = 2'd0,
        ST_FAULT_FREE  = 2'd1,
        ST_FAULT_EVICT = 2'd2,
        ST_NO_FRAME    = 2'd3
    } status_code_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_stat_t;

endpackage

/* sv/ptfr_ctrl.sv */
// Controller state machine for the page translation block.
// Issues load and commit commands to the datapath; uses ptfr_pkg.
module ptfr_ctrl
    import ptfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC, S_WAIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_WAIT;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC, S_WAIT: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/ptfr_datapath.sv */
// Datapath for the page translation block: page table, frame table, FIFO
// ring, counters and the result register. Uses ptfr_pkg.
module ptfr_datapath
    import ptfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [VA_W-1:0]   s_virtual_address,
    input  ctrl_cmd_t         cmd,
    output ctrl_stat_t        stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PA_W-1:0]   m_physical_address,
    output logic [1:0]        m_status,
    output logic              m_flush_request,
    output logic [PA_W-1:0]   m_flush_frame_base,
    output logic [CNT_W-1:0]  m_hit_total,
    output logic [CNT_W-1:0]  m_fault_total
);

    logic [CFG_W-1:0]    frames_in_use_reg;
    logic [VA_W-1:0]     va_reg;
    logic [FRAME_W-1:0]  page_frame_mem [VIRTUAL_PAGES];
    logic [FRAME_W-1:0]  pf_rdata_reg;
    logic [VIRTUAL_PAGES-1:0] page_valid_reg;
    logic [FRAME_SLOTS-1:0]   frame_occ_reg;
    logic [PAGE_W-1:0]   owner_reg [FRAME_SLOTS];
    logic [FRAME_W-1:0]  ring_reg [FRAME_SLOTS];
    logic [FRAME_W-1:0]  head_reg;
    logic [RING_W-1:0]   count_reg;
    logic [CNT_W-1:0]    hit_reg;
    logic [CNT_W-1:0]    fault_reg;

    logic                m_valid_reg;
    logic [PA_W-1:0]     pa_reg;
    status_code_t        status_reg;
    logic                flush_reg;
    logic [PA_W-1:0]     fbase_reg;

    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic                hit;
    logic [CFG_W-1:0]    limit;
    logic                free_found;
    logic [FRAME_W-1:0]  free_frame;
    logic [FRAME_W-1:0]  victim;
    logic [PAGE_W-1:0]   victim_page;
    logic                evict;
    logic                no_frame;
    logic [FRAME_W-1:0]  frame_sel;
    logic [FRAME_W-1:0]  ring_tail;
    logic                do_map;

    assign page   = va_reg[OFFSET_W +: PAGE_W];
    assign offset = va_reg[OFFSET_W-1:0];
    assign hit    = page_valid_reg[page];
    assign limit  = (frames_in_use_reg > CFG_W'(FRAME_SLOTS)) ? CFG_W'(FRAME_SLOTS)
                                                               : frames_in_use_reg;

    // Lowest free frame below the configured limit.
    always_comb begin
        free_found = 1'b0;
        free_frame = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            if (!free_found && !frame_occ_reg[i] && (CFG_W'(i) < limit)) begin
                free_found = 1'b1;
                free_frame = FRAME_W'(i);
            end
        end
    end

    assign victim      = ring_reg[head_reg];
    assign victim_page = owner_reg[victim];
    assign evict       = !hit && !free_found && (count_reg != '0);
    assign no_frame    = !hit && !free_found && (count_reg == '0);
    assign frame_sel   = hit ? pf_rdata_reg : (free_found ? free_frame : victim);
    assign ring_tail   = head_reg + count_reg[FRAME_W-1:0];
    assign do_map      = cmd.commit && !hit && !no_frame;

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= CFG_W'(FRAME_SLOTS);
        end else if (cfg_we) begin
            frames_in_use_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            va_reg       <= s_virtual_address;
            pf_rdata_reg <= page_frame_mem[s_virtual_address[OFFSET_W +: PAGE_W]];
        end
        if (do_map) begin
            page_frame_mem[page] <= frame_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_valid_reg <= '0;
            frame_occ_reg  <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            hit_reg        <= '0;
            fault_reg      <= '0;
        end else if (cmd.commit) begin
            if (hit) begin
                hit_reg <= hit_reg + 1'b1;
            end else begin
                fault_reg <= fault_reg + 1'b1;
            end
            if (evict) begin
                head_reg <= head_reg + 1'b1;
                if (frame_occ_reg[victim]) begin
                    page_valid_reg[victim_page] <= 1'b0;
                end
            end
            if (do_map) begin
                frame_occ_reg[frame_sel] <= 1'b1;
                page_valid_reg[page]     <= 1'b1;
                if (!evict) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_map) begin
            owner_reg[frame_sel] <= page;
            ring_reg[ring_tail]  <= frame_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            flush_reg <= evict;
            if (no_frame) begin
                pa_reg <= '0;
            end else begin
                pa_reg <= PA_W'({frame_sel, offset});
            end
            if (evict) begin
                fbase_reg <= PA_W'({victim, {OFFSET_W{1'b0}}});
            end else begin
                fbase_reg <= '0;
            end
            if (hit) begin
                status_reg <= ST_HIT;
            end else if (free_found) begin
                status_reg <= ST_FAULT_FREE;
            end else if (evict) begin
                status_reg <= ST_FAULT_EVICT;
            end else begin
                status_reg <= ST_NO_FRAME;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = pa_reg;
    assign m_status           = status_reg;
    assign m_flush_request    = flush_reg;
    assign m_flush_frame_base = fbase_reg;
    assign m_hit_total        = hit_reg;
    assign m_fault_total      = fault_reg;

endmodule

/* sv/page_translate_fifo_replace.sv */
// Top level of the page translation block with FIFO frame replacement.
// Joins the controller ptfr_ctrl and the datapath ptfr_datapath; uses ptfr_pkg.
//
// Each transaction on the s_ channel carries one virtual address. Each one
// yields exactly one transaction on the m_ channel with the physical address,
// a status code (hit, fault into a free frame, fault with eviction, or no
// frame), a flush request with the evicted frame base, and the running hit
// and fault totals. The frame count is written through cfg_we and cfg_wdata
// while the block is idle, a user rule the block does not enforce; values above
// the frame table size act as full. A transaction is taken into the address
// register with a synchronous read of the page table; its result and the table
// write-back follow once the output register is free. The next transaction is
// taken while a result still waits on the m_ channel. When the receiver stalls,
// the result stays in the output register and the block holds the following
// item before updating any table until the output register is free. Reset
// clears the page valid bits, frame occupancy, FIFO ring head and count, both
// counters and the output valid, and sets the frame count to sixteen.
module page_translate_fifo_replace
    import ptfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [VA_W-1:0]   s_virtual_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PA_W-1:0]   m_physical_address,
    output logic [1:0]        m_status,
    output logic              m_flush_request,
    output logic [PA_W-1:0]   m_flush_frame_base,
    output logic [CNT_W-1:0]  m_hit_total,
    output logic [CNT_W-1:0]  m_fault_total
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ptfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptfr_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_virtual_address  (s_virtual_address),
        .cmd                (cmd),
        .stat               (stat),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_status           (m_status),
        .m_flush_request    (m_flush_request),
        .m_flush_frame_base (m_flush_frame_base),
        .m_hit_total        (m_hit_total),
        .m_fault_total      (m_fault_total)
    );

endmodule
